/* hdl/eru_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the emission rate accumulator
package eru_pkg;

    localparam int TIME_W     = 32;
    localparam int BURST_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TICK_ADD,
        ST_RECIP_START,
        ST_RECIP_WAIT,
        ST_COUNT_START,
        ST_COUNT_WAIT,
        ST_TICK_DONE,
        ST_CMT_EMIT,
        ST_CMT_MUL,
        ST_CMT_SUB,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_CMT_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic tick_add;
        logic recip_start;
        logic recip_take;
        logic count_start;
        logic count_take;
        logic tick_done;
        logic cmt_emit;
        logic cmt_mul;
        logic cmt_sub;
        logic mod_start;
        logic mod_take;
        logic cmt_done;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic supp;
        logic div_done;
        logic arm;
        logic need_mod;
    } t_stat;

endpackage

/* hdl/eru_ifs.sv */
`timescale 1ns / 1ps
// channel interfaces: frame input, result output and configuration write
interface eru_in_if import eru_pkg::*; #(
    parameter int COUNT_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [TIME_W-1:0]     frame_delta;
    logic [TIME_W-1:0]     emit_rate;
    logic                  pool_empty;
    logic [COUNT_BITS-1:0] extra_count;
    logic [COUNT_BITS-1:0] granted_count;

    modport source (output valid, mode, frame_delta, emit_rate, pool_empty,
                    extra_count, granted_count, input ready);
    modport sink   (input valid, mode, frame_delta, emit_rate, pool_empty,
                    extra_count, granted_count, output ready);
endinterface

interface eru_out_if import eru_pkg::*; #(
    parameter int COUNT_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] request_count;
    logic [COUNT_BITS-1:0] timed_count;
    logic [TIME_W-1:0]     emit_interval;
    logic                  suppressed;
    logic [TIME_W-1:0]     timer_value;

    modport source (output valid, request_count, timed_count, emit_interval,
                    suppressed, timer_value, input ready);
    modport sink   (input valid, request_count, timed_count, emit_interval,
                    suppressed, timer_value, output ready);
endinterface

interface eru_cfg_if import eru_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

/* hdl/emission_rate_accumulator_unit.sv */
`timescale 1ns / 1ps
// top level of the emission rate accumulator
//
// channel  dir  handshake     payload
// i_cfg    in   valid/ready   wr_index, wr_data (ready always high)
// i_in     in   valid/ready   mode, frame_delta, emit_rate, pool_empty,
//                             extra_count, granted_count
// o_out    out  valid/ready   request_count, timed_count, emit_interval,
//                             suppressed, timer_value
//
// one transaction in flight; DIV_W = max(2*TIME_FRAC_BITS+1, 32), 33 by default
// frame tick: two passes of the shared one-bit-per-cycle divider, reciprocal then
//   count; a suppressed tick skips the divider
// commit: ignored when disarmed, else applied by multiply and subtract; with a full
//   grant in single mode the remainder is also reduced modulo the interval
// synchronous active-low reset; no clearing pass, the block is ready at once
// a stalled output holds its result; the next transaction is taken meanwhile
module emission_rate_accumulator_unit import eru_pkg::*; #(
    parameter int COUNT_BITS     = 16,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eru_cfg_if.sink   i_cfg,
    eru_in_if.sink    i_in,
    eru_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  out_valid;

    // register writes need no wait, so the port never stalls
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    // sequencer: owns the handshakes and steps the datapath
    eru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath: config, accumulator, divider, multiplier and result register
    eru_dp #(
        .COUNT_BITS     (COUNT_BITS),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_idx       (i_cfg.wr_index),
        .i_cfg_data      (i_cfg.wr_data),
        .i_mode          (i_in.mode),
        .i_frame_delta   (i_in.frame_delta),
        .i_emit_rate     (i_in.emit_rate),
        .i_pool_empty    (i_in.pool_empty),
        .i_extra_count   (i_in.extra_count),
        .i_granted_count (i_in.granted_count),
        .o_request_count (o_out.request_count),
        .o_timed_count   (o_out.timed_count),
        .o_emit_interval (o_out.emit_interval),
        .o_suppressed    (o_out.suppressed),
        .o_timer_value   (o_out.timer_value)
    );

endmodule

/* hdl/eru_div.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module eru_div #(
    parameter int DIV_W = 33,
    parameter int DVS_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
            r_busy <= (r_cnt != CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* hdl/eru_dp.sv */
`timescale 1ns / 1ps
// datapath: configuration, accumulator state, divider, multiplier, result register
module eru_dp import eru_pkg::*; #(
    parameter int COUNT_BITS     = 16,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_mode,
    input  logic [TIME_W-1:0]     i_frame_delta,
    input  logic [TIME_W-1:0]     i_emit_rate,
    input  logic                  i_pool_empty,
    input  logic [COUNT_BITS-1:0] i_extra_count,
    input  logic [COUNT_BITS-1:0] i_granted_count,
    output logic [COUNT_BITS-1:0] o_request_count,
    output logic [COUNT_BITS-1:0] o_timed_count,
    output logic [TIME_W-1:0]     o_emit_interval,
    output logic                  o_suppressed,
    output logic [TIME_W-1:0]     o_timer_value
);

    localparam int DIV_W  = (2 * TIME_FRAC_BITS + 1 > TIME_W) ? 2 * TIME_FRAC_BITS + 1 : TIME_W;
    localparam int USED_W = TIME_W + COUNT_BITS;
    localparam logic [63:0] CNT_MAX64  = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] TIME_MAX64 = 64'hFFFF_FFFF;

    // configuration
    logic [TIME_W-1:0]     r_lifetime;
    logic [BURST_W-1:0]    r_burst;
    logic                  r_single;
    // latched transaction
    logic                  r_mode;
    logic [TIME_W-1:0]     r_delta;
    logic [TIME_W-1:0]     r_rate;
    logic                  r_empty;
    logic [COUNT_BITS-1:0] r_pending;
    logic [COUNT_BITS-1:0] r_granted;
    // persistent state
    logic [TIME_W-1:0]     r_elapsed;
    logic [TIME_W-1:0]     r_accum;
    logic [TIME_W-1:0]     r_held_interval;
    logic [COUNT_BITS-1:0] r_held_timed;
    logic [COUNT_BITS-1:0] r_held_pending;
    logic                  r_held_supp;
    logic                  r_supp;
    // working registers
    logic [TIME_W-1:0]     r_interval;
    logic [COUNT_BITS-1:0] r_timed;
    logic [COUNT_BITS-1:0] r_emitted;
    logic [USED_W-1:0]     r_used;
    logic [TIME_W-1:0]     r_rem;
    // result register
    logic [COUNT_BITS-1:0] r_out_request;
    logic [COUNT_BITS-1:0] r_out_timed;
    logic [TIME_W-1:0]     r_out_interval;
    logic                  r_out_supp;
    logic [TIME_W-1:0]     r_out_timer;

    logic [TIME_W:0]       sum_elapsed;
    logic [TIME_W:0]       sum_accum;
    logic [TIME_W-1:0]     n_elapsed;
    logic [TIME_W-1:0]     n_accum;
    logic                  supp_now;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [TIME_W-1:0]     div_divisor;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quo;
    logic [TIME_W-1:0]     div_rem;
    logic [63:0]           quo_x;
    logic [TIME_W-1:0]     recip_val;
    logic [COUNT_BITS-1:0] timed_val;
    logic [COUNT_BITS:0]   req_sum;
    logic [COUNT_BITS-1:0] req_val;
    logic [COUNT_BITS-1:0] emitted_val;
    logic [USED_W-1:0]     accum_x;
    logic [USED_W-1:0]     rem_diff;
    logic [TIME_W-1:0]     rem_sub;
    logic [TIME_W-1:0]     rem_clamped;
    logic                  short_fill;
    logic                  arm;

    assign sum_elapsed = {1'b0, r_elapsed} + {1'b0, r_delta};
    assign sum_accum   = {1'b0, r_accum} + {1'b0, r_delta};
    assign n_elapsed   = sum_elapsed[TIME_W] ? '1 : sum_elapsed[TIME_W-1:0];
    assign n_accum     = sum_accum[TIME_W] ? '1 : sum_accum[TIME_W-1:0];
    assign supp_now    = (r_lifetime != '0) && (n_elapsed > r_lifetime) && (r_pending == '0);

    // divider operand select
    always_comb begin
        div_start    = i_cmd.recip_start | i_cmd.count_start | i_cmd.mod_start;
        div_dividend = '0;
        div_divisor  = '0;
        if (i_cmd.recip_start) begin
            div_dividend = {{(DIV_W-1){1'b0}}, 1'b1} << (2 * TIME_FRAC_BITS);
            div_divisor  = r_rate;
        end else if (i_cmd.count_start) begin
            div_dividend = DIV_W'(r_accum);
            div_divisor  = r_interval;
        end else if (i_cmd.mod_start) begin
            div_dividend = DIV_W'(r_rem);
            div_divisor  = r_held_interval;
        end
    end

    eru_div #(
        .DIV_W (DIV_W),
        .DVS_W (TIME_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign quo_x = 64'(div_quo);

    // interval: truncated, saturated, at least one for a nonzero rate
    always_comb begin
        if (r_rate == '0) begin
            recip_val = '0;
        end else if (quo_x > TIME_MAX64) begin
            recip_val = '1;
        end else if (quo_x == 64'd0) begin
            recip_val = TIME_W'(1);
        end else begin
            recip_val = div_quo[TIME_W-1:0];
        end
    end

    // items due: burst when the pool is empty, else accumulator over interval (capped at one in single mode)
    always_comb begin
        if (r_burst != '0 && r_empty) begin
            timed_val = (64'(r_burst) > CNT_MAX64) ? '1 : COUNT_BITS'(r_burst);
        end else if (r_interval == '0) begin
            timed_val = '0;
        end else begin
            timed_val = (quo_x > CNT_MAX64) ? '1 : div_quo[COUNT_BITS-1:0];
            if (r_single && timed_val > COUNT_BITS'(1)) begin
                timed_val = COUNT_BITS'(1);
            end
        end
    end

    assign req_sum = {1'b0, r_timed} + {1'b0, r_pending};
    assign req_val = req_sum[COUNT_BITS] ? '1 : req_sum[COUNT_BITS-1:0];

    // commit arithmetic
    assign emitted_val = (r_granted > r_held_pending) ? (r_granted - r_held_pending) : '0;
    assign accum_x     = USED_W'(r_accum);
    assign rem_diff    = accum_x - r_used;
    assign rem_sub     = (accum_x > r_used) ? rem_diff[TIME_W-1:0] : '0;
    assign short_fill  = r_emitted < r_held_timed;
    assign rem_clamped = (short_fill && rem_sub > r_held_interval) ? r_held_interval : rem_sub;
    assign arm = !r_held_supp && (r_held_timed != '0) && (r_held_interval != '0);

    assign o_stat.mode     = r_mode;
    assign o_stat.supp     = r_supp;
    assign o_stat.div_done = div_done;
    assign o_stat.arm      = arm;
    assign o_stat.need_mod = !short_fill && r_single;

    // state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime      <= '0;
            r_burst         <= '0;
            r_single        <= 1'b0;
            r_elapsed       <= '0;
            r_accum         <= '0;
            r_held_interval <= '0;
            r_held_timed    <= '0;
            r_held_pending  <= '0;
            r_held_supp     <= 1'b1;
            r_supp          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIFETIME: r_lifetime <= i_cfg_data[TIME_W-1:0];
                    CFG_BURST:    r_burst    <= i_cfg_data[BURST_W-1:0];
                    CFG_SINGLE:   r_single   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.tick_add) begin
                r_elapsed <= n_elapsed;
                r_supp    <= supp_now;
                if (!supp_now) begin
                    r_accum <= n_accum;
                end
            end
            if (i_cmd.tick_done) begin
                if (r_supp) begin
                    r_held_interval <= '0;
                    r_held_timed    <= '0;
                    r_held_pending  <= '0;
                    r_held_supp     <= 1'b1;
                end else begin
                    r_held_interval <= r_interval;
                    r_held_timed    <= r_timed;
                    r_held_pending  <= r_pending;
                    r_held_supp     <= 1'b0;
                end
            end
            if (i_cmd.cmt_done) begin
                if (arm) begin
                    r_accum <= r_rem;
                end
                r_held_supp <= 1'b1;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode    <= i_mode;
            r_delta   <= i_frame_delta;
            r_rate    <= i_emit_rate;
            r_empty   <= i_pool_empty;
            r_pending <= i_extra_count;
            r_granted <= i_granted_count;
        end
        if (i_cmd.recip_take) begin
            r_interval <= recip_val;
        end
        if (i_cmd.count_take) begin
            r_timed <= timed_val;
        end
        if (i_cmd.cmt_emit) begin
            r_emitted <= emitted_val;
        end
        if (i_cmd.cmt_mul) begin
            r_used <= USED_W'(r_held_interval) * USED_W'(r_emitted);
        end
        if (i_cmd.cmt_sub) begin
            r_rem <= rem_clamped;
        end
        if (i_cmd.mod_take) begin
            r_rem <= div_rem;
        end
        if (i_cmd.tick_done) begin
            r_out_timer <= r_accum;
            if (r_supp) begin
                r_out_request  <= '0;
                r_out_timed    <= '0;
                r_out_interval <= '0;
                r_out_supp     <= 1'b1;
            end else begin
                r_out_request  <= req_val;
                r_out_timed    <= r_timed;
                r_out_interval <= r_interval;
                r_out_supp     <= 1'b0;
            end
        end
        if (i_cmd.cmt_done) begin
            r_out_request  <= '0;
            r_out_timed    <= '0;
            r_out_interval <= '0;
            r_out_supp     <= 1'b0;
            r_out_timer    <= arm ? r_rem : r_accum;
        end
    end

    assign o_request_count = r_out_request;
    assign o_timed_count   = r_out_timed;
    assign o_emit_interval = r_out_interval;
    assign o_suppressed    = r_out_supp;
    assign o_timer_value   = r_out_timer;

endmodule

/* hdl/eru_ctrl.sv */
`timescale 1ns / 1ps
// control state machine: sequences tick and commit through the datapath
module eru_ctrl import eru_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   load_out;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:        if (i_in_valid) n_state = ST_DISPATCH;
            ST_DISPATCH:    n_state = i_stat.mode ? ST_CMT_EMIT : ST_TICK_ADD;
            ST_TICK_ADD:    n_state = ST_RECIP_START;
            ST_RECIP_START: n_state = i_stat.supp ? ST_TICK_DONE : ST_RECIP_WAIT;
            ST_RECIP_WAIT:  if (i_stat.div_done) n_state = ST_COUNT_START;
            ST_COUNT_START: n_state = ST_COUNT_WAIT;
            ST_COUNT_WAIT:  if (i_stat.div_done) n_state = ST_TICK_DONE;
            ST_TICK_DONE:   if (out_free) n_state = ST_IDLE;
            ST_CMT_EMIT:    n_state = i_stat.arm ? ST_CMT_MUL : ST_CMT_DONE;
            ST_CMT_MUL:     n_state = ST_CMT_SUB;
            ST_CMT_SUB:     n_state = i_stat.need_mod ? ST_MOD_START : ST_CMT_DONE;
            ST_MOD_START:   n_state = ST_MOD_WAIT;
            ST_MOD_WAIT:    if (i_stat.div_done) n_state = ST_CMT_DONE;
            ST_CMT_DONE:    if (out_free) n_state = ST_IDLE;
            default:        n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_TICK_ADD:    o_cmd.tick_add    = 1'b1;
            ST_RECIP_START: o_cmd.recip_start = !i_stat.supp;
            ST_RECIP_WAIT:  o_cmd.recip_take  = i_stat.div_done;
            ST_COUNT_START: o_cmd.count_start = 1'b1;
            ST_COUNT_WAIT:  o_cmd.count_take  = i_stat.div_done;
            ST_TICK_DONE:   o_cmd.tick_done   = out_free;
            ST_CMT_EMIT:    o_cmd.cmt_emit    = 1'b1;
            ST_CMT_MUL:     o_cmd.cmt_mul     = 1'b1;
            ST_CMT_SUB:     o_cmd.cmt_sub     = 1'b1;
            ST_MOD_START:   o_cmd.mod_start   = 1'b1;
            ST_MOD_WAIT:    o_cmd.mod_take    = i_stat.div_done;
            ST_CMT_DONE:    o_cmd.cmt_done    = out_free;
            default: ;
        endcase
    end

    assign load_out    = o_cmd.tick_done | o_cmd.cmt_done;
    assign n_out_valid = load_out ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/eru_chk.sv */
`timescale 1ns / 1ps
// port-level checker for the emission rate accumulator, bound to the top level
module eru_chk import eru_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COUNT_BITS-1:0] i_request_count,
    input logic [COUNT_BITS-1:0] i_timed_count,
    input logic [TIME_W-1:0]     i_emit_interval,
    input logic                  i_suppressed,
    input logic [TIME_W-1:0]     i_timer_value
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before taken");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_request_count) && $stable(i_timed_count) &&
            $stable(i_emit_interval) && $stable(i_suppressed) && $stable(i_timer_value))
        else $error("stalled result changed");

    // a suppressed tick reports no items and no interval
    a_supp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_suppressed |->
            i_request_count == '0 && i_timed_count == '0 && i_emit_interval == '0)
        else $error("suppressed result carries counts");

    // saturating sum never falls below its timed part
    a_req_ge_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_request_count >= i_timed_count)
        else $error("request count below timed count");

    // one transaction at a time: no accept right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !(i_in_valid && i_in_ready))
        else $error("back-to-back input accepted");

endmodule

bind emission_rate_accumulator_unit eru_chk #(
    .COUNT_BITS (COUNT_BITS)
) u_eru_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_request_count (o_out.request_count),
    .i_timed_count   (o_out.timed_count),
    .i_emit_interval (o_out.emit_interval),
    .i_suppressed    (o_out.suppressed),
    .i_timer_value   (o_out.timer_value)
);

/* verif/emission_rate_accumulator_unit_test.sv */
`timescale 1ns / 1ps
// self-checking testbench of the emission rate accumulator with a transaction-level predictor
module emission_rate_accumulator_unit_test import eru_pkg::*; ();

    localparam int COUNT_BITS     = 16;
    localparam int TIME_FRAC_BITS = 16;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_COMMIT = 1'b1;

    localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] TIME_LIMIT  = 64'hFFFF_FFFF;
    localparam logic [63:0] RECIP_NUM   = 64'd1 << (2 * TIME_FRAC_BITS);

    localparam logic [31:0] ONE_SEC  = 32'h0001_0000;
    localparam logic [31:0] HALF_SEC = 32'h0000_8000;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int SETTLE_CYCLES   = 100;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int NUM_ROWS        = 27;

    typedef struct packed {
        logic                  mode;
        logic [TIME_W-1:0]     frame_delta;
        logic [TIME_W-1:0]     emit_rate;
        logic                  pool_empty;
        logic [COUNT_BITS-1:0] extra_count;
        logic [COUNT_BITS-1:0] granted_count;
    } t_frame_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0] request_count;
        logic [COUNT_BITS-1:0] timed_count;
        logic [TIME_W-1:0]     emit_interval;
        logic                  suppressed;
        logic [TIME_W-1:0]     timer_value;
    } t_emit_result;

    typedef enum logic {
        ROW_WRITE,
        ROW_ITEM
    } t_row_kind;

    // one line of the directed sequence: a register write or a frame transaction,
    // optionally with a hand-written result that replaces the predicted one
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        t_frame_item           item;
        logic                  typed;
        t_emit_result          result;
    } t_stim_row;

    logic clk;
    logic rst_n;

    eru_cfg_if                           cfg_if ();
    eru_in_if  #(.COUNT_BITS(COUNT_BITS)) in_if ();
    eru_out_if #(.COUNT_BITS(COUNT_BITS)) out_if ();

    emission_rate_accumulator_unit #(
        .COUNT_BITS    (COUNT_BITS),
        .TIME_FRAC_BITS(TIME_FRAC_BITS)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cfg  (cfg_if),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // predictor copy of the registers
    logic [31:0] life_limit;
    logic [15:0] burst_size;
    logic        single_cap;

    // predictor copy of the accumulator state
    logic [31:0] elapsed_q;
    logic [31:0] accum_q;
    logic [31:0] tick_interval;
    logic [15:0] tick_timed;
    logic [15:0] tick_pending;
    logic        disarmed;

    t_emit_result predicted_emissions[$];

    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned results_seen;
    int unsigned tick_count;
    int unsigned commit_count;
    int unsigned suppressed_count;
    int unsigned write_count;
    logic        gaps_on;
    logic        rx_stalls_on;

    t_stim_row   stim_rows [NUM_ROWS];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog, far above the slowest legal run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     predicted_emissions.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] add_saturate(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TIME_MAX : s[31:0];
    endfunction

    // advances the predictor by one transaction and returns the result it causes
    function automatic t_emit_result predict_emission(input t_frame_item it);
        t_emit_result r;
        logic [63:0]  interval;
        logic [63:0]  timed;
        logic [63:0]  request;
        logic [63:0]  emitted;
        logic [63:0]  used;
        logic [63:0]  rem;
        r = '0;
        if (it.mode == MODE_TICK) begin
            elapsed_q = add_saturate(elapsed_q, it.frame_delta);
            // past the lifetime with nothing pending: time moves, timer stays
            if (life_limit != 0 && elapsed_q > life_limit && it.extra_count == 0) begin
                disarmed      = 1'b1;
                tick_timed    = '0;
                tick_pending  = '0;
                tick_interval = '0;
                r.suppressed  = 1'b1;
                r.timer_value = accum_q;
                return r;
            end
            accum_q = add_saturate(accum_q, it.frame_delta);
            if (it.emit_rate == 0) begin
                interval = 0;
            end else begin
                interval = RECIP_NUM / {32'd0, it.emit_rate};
                if (interval > TIME_LIMIT) interval = TIME_LIMIT;
                if (interval == 0) interval = 1;
            end
            if (burst_size != 0 && it.pool_empty) begin
                timed = {48'd0, burst_size};
            end else if (interval == 0) begin
                timed = 0;
            end else begin
                timed = {32'd0, accum_q} / interval;
                if (timed > COUNT_LIMIT) timed = COUNT_LIMIT;
                if (single_cap && timed > 1) timed = 1;
            end
            request = timed + {48'd0, it.extra_count};
            if (request > COUNT_LIMIT) request = COUNT_LIMIT;
            tick_interval   = interval[31:0];
            tick_timed      = timed[15:0];
            tick_pending    = it.extra_count;
            disarmed        = 1'b0;
            r.request_count = request[15:0];
            r.timed_count   = timed[15:0];
            r.emit_interval = interval[31:0];
            r.timer_value   = accum_q;
        end else begin
            if (!disarmed && tick_timed != 0 && tick_interval != 0) begin
                emitted = (it.granted_count > tick_pending) ?
                          {48'd0, it.granted_count} - {48'd0, tick_pending} : 64'd0;
                used = {32'd0, tick_interval} * emitted;
                rem  = ({32'd0, accum_q} > used) ? {32'd0, accum_q} - used : 64'd0;
                // short grant keeps at most one interval; full grant with the
                // one-per-frame cap drops whole intervals
                if (emitted < {48'd0, tick_timed}) begin
                    if (rem > {32'd0, tick_interval}) rem = {32'd0, tick_interval};
                end else if (single_cap) begin
                    rem = rem % {32'd0, tick_interval};
                end
                accum_q = rem[31:0];
            end
            disarmed      = 1'b1;
            r.timer_value = accum_q;
        end
        return r;
    endfunction

    function automatic t_frame_item random_tick();
        t_frame_item it;
        int unsigned pick;
        it.mode          = MODE_TICK;
        it.granted_count = 16'($urandom);
        it.pool_empty    = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 19);
        if (pick == 0) it.frame_delta = $urandom;
        else if (pick < 3) it.frame_delta = '0;
        else it.frame_delta = $urandom_range(0, HALF_SEC);
        pick = $urandom_range(0, 19);
        if (pick < 2) it.emit_rate = '0;
        else if (pick < 4) it.emit_rate = $urandom;
        else if (pick == 4) it.emit_rate = $urandom_range(32'hF000_0000, TIME_MAX);
        else it.emit_rate = $urandom_range(32'h100, 32'h0258_0000);
        pick = $urandom_range(0, 19);
        if (pick < 10) it.extra_count = '0;
        else if (pick < 17) it.extra_count = 16'($urandom_range(1, 8));
        else it.extra_count = 16'($urandom);
        return it;
    endfunction

    // commit with random bits in the fields that a commit ignores
    function automatic t_frame_item commit_item(input logic [15:0] granted);
        t_frame_item it;
        it.mode          = MODE_COMMIT;
        it.frame_delta   = $urandom;
        it.emit_rate     = $urandom;
        it.pool_empty    = 1'($urandom_range(0, 1));
        it.extra_count   = 16'($urandom);
        it.granted_count = granted;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(input t_frame_item it, input logic typed,
                             input t_emit_result typed_res);
        int unsigned  gap;
        t_emit_result res;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.mode          <= it.mode;
        in_if.frame_delta   <= it.frame_delta;
        in_if.emit_rate     <= it.emit_rate;
        in_if.pool_empty    <= it.pool_empty;
        in_if.extra_count   <= it.extra_count;
        in_if.granted_count <= it.granted_count;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        res = predict_emission(it);
        predicted_emissions.push_back(typed ? typed_res : res);
        if (it.mode == MODE_TICK) tick_count++;
        else commit_count++;
        if (res.suppressed) suppressed_count++;
        @(negedge clk);
    endtask

    // holds the sender until every result is back; the block is then idle
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(negedge clk);
        while (predicted_emissions.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid    <= 1'b1;
        cfg_if.wr_index <= index;
        cfg_if.wr_data  <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (index)
            CFG_LIFETIME: life_limit = value;
            CFG_BURST:    burst_size = value[15:0];
            CFG_SINGLE:   single_cap = value[0];
            default: ;
        endcase
        write_count++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic check_emission();
        t_emit_result exp_r;
        if (predicted_emissions.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual timer %0h",
                     $time, out_if.timer_value);
            error_count++;
        end else begin
            exp_r = predicted_emissions.pop_front();
            check_field("request_count", exp_r.request_count, out_if.request_count);
            check_field("timed_count", exp_r.timed_count, out_if.timed_count);
            check_field("emit_interval", exp_r.emit_interval, out_if.emit_interval);
            check_field("suppressed", exp_r.suppressed, out_if.suppressed);
            check_field("timer_value", exp_r.timer_value, out_if.timer_value);
        end
    endtask

    // result side: random stall before each transaction, sometimes none at all
    initial begin
        int unsigned stall;
        out_if.ready <= 1'b0;
        rx_stalls_on = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = rx_stalls_on ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
            check_emission();
            results_seen++;
            if (results_seen % 64 == 0) rx_stalls_on = ($urandom_range(0, 3) != 0);
            @(negedge clk);
        end
    end

    initial begin
        int unsigned       phase_items;
        int unsigned       pick;
        logic [15:0]       granted;
        t_emit_result      no_result;
        t_frame_item       no_item;

        no_result = '0;
        no_item   = '0;

        // every input known from time zero
        rst_n               <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.wr_index     <= CFG_LIFETIME;
        cfg_if.wr_data      <= '0;
        in_if.valid         <= 1'b0;
        in_if.mode          <= MODE_TICK;
        in_if.frame_delta   <= '0;
        in_if.emit_rate     <= '0;
        in_if.pool_empty    <= 1'b0;
        in_if.extra_count   <= '0;
        in_if.granted_count <= '0;

        cycle_count      = 0;
        error_count      = 0;
        results_seen     = 0;
        tick_count       = 0;
        commit_count     = 0;
        suppressed_count = 0;
        write_count      = 0;
        gaps_on          = 1'b1;

        // predictor reset image; commit disarmed until the first tick
        life_limit    = '0;
        burst_size    = '0;
        single_cap    = 1'b0;
        elapsed_q     = '0;
        accum_q       = '0;
        tick_interval = '0;
        tick_timed    = '0;
        tick_pending  = '0;
        disarmed      = 1'b1;

        // directed sequence, typed results only where they are obvious
        stim_rows = '{
            // commit straight after reset is ignored
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'hFFFF}, 1'b1, no_result},
            // all-zero tick: zero rate, nothing due
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, 32'd0, 32'd0, 1'b0, 16'd0, 16'd0}, 1'b1, no_result},
            // two due plus three pending, then a full grant and a repeated commit
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, HALF_SEC, 4 * ONE_SEC, 1'b0, 16'd3, 16'd0}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'd5}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'd5}, 1'b0, no_result},
            // largest rate gives the one-unit interval; pending saturates the request
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, 32'd1, TIME_MAX, 1'b1, 16'hFFFF, 16'd0}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'd0}, 1'b0, no_result},
            // smallest rate: interval saturates, nothing due, commit ignored
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, 32'd0, 32'd1, 1'b0, 16'd0, 16'd0}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'hFFFF}, 1'b0, no_result},
            // one per frame: cap and modulo remainder
            '{ROW_WRITE, CFG_SINGLE, 32'd1, no_item, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, 3 * ONE_SEC, 2 * ONE_SEC, 1'b0, 16'd0, 16'd0}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'd1}, 1'b0, no_result},
            // largest burst, with zero rate and with a real rate
            '{ROW_WRITE, CFG_BURST, 32'h0000_FFFF, no_item, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, 32'h100, 32'd0, 1'b1, 16'd2, 16'd0}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'hFFFF}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, 32'h100, ONE_SEC, 1'b1, 16'd2, 16'd0}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'd10}, 1'b0, no_result},
            '{ROW_WRITE, CFG_BURST, 32'd0, no_item, 1'b0, no_result},
            '{ROW_WRITE, CFG_SINGLE, 32'd0, no_item, 1'b0, no_result},
            // lifetime runs out: suppressed tick, then pending overrides it
            '{ROW_WRITE, CFG_LIFETIME, 4 * ONE_SEC, no_item, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, ONE_SEC, ONE_SEC, 1'b0, 16'd0, 16'd0}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'd5}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, 32'h100, ONE_SEC, 1'b0, 16'd7, 16'd0}, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'd7}, 1'b0, no_result},
            // largest lifetime and delta: both time counters saturate
            '{ROW_WRITE, CFG_LIFETIME, TIME_MAX, no_item, 1'b0, no_result},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_TICK, TIME_MAX, ONE_SEC, 1'b0, 16'd0, 16'd0}, 1'b1,
              '{16'hFFFF, 16'hFFFF, ONE_SEC, 1'b0, TIME_MAX}},
            '{ROW_ITEM, CFG_LIFETIME, 32'd0,
              '{MODE_COMMIT, 32'd0, 32'd0, 1'b0, 16'd0, 16'hFFFF}, 1'b0, no_result}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                drain_results();
                write_reg(stim_rows[i].reg_index, stim_rows[i].reg_value);
            end else begin
                send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].result);
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_reg(CFG_LIFETIME, 32'd0);
                    write_reg(CFG_BURST, 32'd0);
                    write_reg(CFG_SINGLE, 32'd0);
                end
                1: begin
                    write_reg(CFG_LIFETIME, $urandom_range(1, TIME_MAX - 1));
                    write_reg(CFG_BURST, $urandom_range(1, 16));
                    write_reg(CFG_SINGLE, 32'd1);
                end
                2: begin
                    write_reg(CFG_LIFETIME, TIME_MAX);
                    write_reg(CFG_BURST, 32'h0000_FFFF);
                    write_reg(CFG_SINGLE, 32'd0);
                end
                3: begin
                    write_reg(CFG_LIFETIME, 32'd0);
                    write_reg(CFG_BURST, $urandom_range(1, 16'hFFFF));
                end
                default: begin
                    write_reg(CFG_BURST, 32'd0);
                    write_reg(CFG_SINGLE, 32'd1);
                end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    // well-formed frame: tick, then a commit sized from its request
                    send_item(random_tick(), 1'b0, no_result);
                    pick = $urandom_range(0, 9);
                    if (pick < 4) granted = predicted_emissions.size() != 0 ?
                                            predicted_emissions[$].request_count : 16'd0;
                    else if (pick < 7) granted = 16'($urandom_range(0,
                                            predicted_emissions.size() != 0 ?
                                            predicted_emissions[$].request_count : 0));
                    else if (pick == 7) granted = tick_pending;
                    else if (pick == 8) granted = 16'($urandom);
                    else granted = '0;
                    send_item(commit_item(granted), 1'b0, no_result);
                    phase_items += 2;
                end else if (pick < 93) begin
                    send_item(random_tick(), 1'b0, no_result);
                    phase_items += 1;
                end else begin
                    send_item(commit_item(16'($urandom)), 1'b0, no_result);
                    phase_items += 1;
                end
                if ($urandom_range(0, 59) == 0) drain_results();
                if ($urandom_range(0, 39) == 0) gaps_on = ~gaps_on;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d frame ticks (%0d suppressed) and %0d commits over %0d register writes",
                 tick_count, suppressed_count, commit_count, write_count);
        $display("checked %0d results, %0d field mismatches", results_seen, error_count);
        if (error_count == 0 && predicted_emissions.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
